>>> hdl/atte_pkg.sv
// Package for the ANSI text terminal engine: geometry, payload structs,
// byte codes and the queue entry passed from the front parser to the back end.
// No dependencies.
package atte_pkg;

  localparam int unsigned COLUMNS    = 80;
  localparam int unsigned ROWS       = 25;
  localparam int unsigned MAX_PARAMS = 8;
  localparam int unsigned CELLS      = ROWS * COLUMNS;
  localparam int unsigned ADDR_W     = $clog2(CELLS);
  localparam int unsigned PIDX_W     = $clog2(MAX_PARAMS + 1);
  localparam int unsigned PSEL_W     = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam logic [13:0] PARAM_LIMIT = 14'd9999;
  localparam logic [7:0]  SPACE_GLYPH = 8'h20;
  localparam logic [7:0]  ATTR_RESET  = 8'h0F;

  localparam logic [7:0] CH_ESC = 8'h1B;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LBR = 8'h5B;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_ESC    = 2'd1;
  localparam logic [1:0] MODE_CSI    = 2'd2;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic [7:0]  attribute_now;
    logic [15:0] cell_data;
    logic [1:0]  parser_mode;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_BYTE, OP_CSI, OP_READ
  } op_e;

  // Command handed to the back end; params are snapshot at the final byte.
  typedef struct packed {
    op_e                         op;
    logic [7:0]                  ch;
    logic [4:0]                  rd_row;
    logic [6:0]                  rd_col;
    logic [1:0]                  mode;
    logic [PIDX_W-1:0]           pcount;
    logic [MAX_PARAMS-1:0][13:0] params;
  } cmd_t;

  function automatic logic [2:0] color_map(input logic [2:0] c);
    logic [2:0] r;
    r = {c[0], c[1], c[2]};
    return r;
  endfunction

endpackage

>>> hdl/atte_front.sv
// Front part: accepts items, runs the escape and CSI parameter parser and
// emits one command per item into the queue. Depends on atte_pkg.
module atte_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  atte_pkg::in_item_t in_data_i,
  output logic              cmd_valid_o,
  input  logic              cmd_full_i,
  output atte_pkg::cmd_t    cmd_o
);
  import atte_pkg::*;

  logic [1:0]                  mode_q, mode_d;
  logic [PIDX_W-1:0]           pcnt_q, pcnt_d;
  logic [13:0]                 acc_q, acc_d;
  logic                        seen_q, seen_d;
  logic [MAX_PARAMS-1:0][13:0] par_q, par_d;
  logic                        take;
  logic [7:0]                  ch;
  logic [17:0]                 prod;

  assign in_stall_o  = cmd_full_i;
  assign take        = in_valid_i && !cmd_full_i;
  assign cmd_valid_o = take;
  assign ch          = in_data_i.char_code;
  assign prod = {acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {10'd0, ch - 8'h30};

  always_comb begin
    logic push;
    push   = 1'b0;
    mode_d = mode_q;
    pcnt_d = pcnt_q;
    acc_d  = acc_q;
    seen_d = seen_q;
    par_d  = par_q;
    cmd_o        = '0;
    cmd_o.op     = OP_NONE;
    cmd_o.ch     = ch;
    cmd_o.rd_row = in_data_i.read_row;
    cmd_o.rd_col = in_data_i.read_col;
    if (in_data_i.kind) begin
      cmd_o.op = OP_READ;
    end else begin
      case (mode_q)
        MODE_NORMAL: begin
          if (ch == CH_ESC) mode_d = MODE_ESC;
          else cmd_o.op = OP_BYTE;
        end
        MODE_ESC: begin
          if (ch == CH_LBR) begin
            mode_d = MODE_CSI;
            pcnt_d = '0;
            acc_d  = '0;
            seen_d = 1'b0;
          end else begin
            mode_d = MODE_NORMAL;
          end
        end
        default: begin
          if (ch inside {[8'h30:8'h39]}) begin
            acc_d  = (prod > 18'(PARAM_LIMIT)) ? PARAM_LIMIT : prod[13:0];
            seen_d = 1'b1;
          end else if (ch == CH_SEMI) begin
            push = 1'b1;
          end else if (ch inside {[8'h40:8'h7E]}) begin
            push     = seen_q || (pcnt_q == '0);
            mode_d   = MODE_NORMAL;
            cmd_o.op = OP_CSI;
          end else begin
            mode_d = MODE_NORMAL;
          end
        end
      endcase
      if (push) begin
        if (pcnt_q < PIDX_W'(MAX_PARAMS)) begin
          par_d[pcnt_q[PSEL_W-1:0]] = acc_q;
          pcnt_d = pcnt_q + 1'b1;
        end
        acc_d  = '0;
        seen_d = 1'b0;
      end
    end
    cmd_o.mode   = mode_d;
    cmd_o.pcount = pcnt_d;
    cmd_o.params = par_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      pcnt_q <= '0;
      acc_q  <= '0;
      seen_q <= 1'b0;
    end else if (take) begin
      mode_q <= mode_d;
      pcnt_q <= pcnt_d;
      acc_q  <= acc_d;
      seen_q <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) par_q <= par_d;
  end

endmodule

>>> hdl/atte_queue.sv
// Two-entry command queue between the parser and the back end.
// Depends on atte_pkg.
module atte_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  atte_pkg::cmd_t data_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output atte_pkg::cmd_t data_o
);
  import atte_pkg::*;

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

endmodule

>>> hdl/atte_back.sv
// Back end: carries out commands on the cursor, attribute and screen memory,
// with sequencers for scroll, erase, SGR and the clearing pass. Depends on atte_pkg.
module atte_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         def_attr_i,
  input  logic               cmd_valid_i,
  input  atte_pkg::cmd_t     cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output atte_pkg::out_item_t out_data_o
);
  import atte_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SCR_RD, S_SCR_WR, S_BLANK, S_SGR, S_READ, S_OUT
  } state_e;

  state_e                state_q;
  logic [15:0]           mem [CELLS];
  logic [15:0]           rdata_q;
  logic [ADDR_W-1:0]     ptr_q, end_q;
  logic [4:0]            row_q;
  logic [6:0]            col_q;
  logic [7:0]            attr_q;
  logic [PIDX_W-1:0]     sidx_q;
  logic                  isread_q;
  cmd_t                  c_q;
  out_item_t             out_q;
  logic                  out_v_q;
  logic                  we;
  logic [ADDR_W-1:0]     waddr, raddr;
  logic [15:0]           wdata;

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [4:0] r, input logic [6:0] c);
    return ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c);
  endfunction

  // Memory port: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  logic [13:0] n0, p0, p1, sp;
  logic [13:0] nmv;
  always_comb begin
    p0  = (c_q.pcount > 0) ? c_q.params[0] : 14'd1;
    p1  = (c_q.pcount > 1 && MAX_PARAMS > 1) ? c_q.params[PSEL_W'(1 % MAX_PARAMS)] : 14'd1;
    n0  = (c_q.pcount > 0) ? c_q.params[0] : 14'd0;
    nmv = (p0 == 14'd0) ? 14'd1 : p0;
    sp  = c_q.params[sidx_q[PSEL_W-1:0]];
  end

  always_comb begin
    we    = 1'b0;
    waddr = ptr_q;
    wdata = {attr_q, SPACE_GLYPH};
    raddr = ptr_q + ADDR_W'(COLUMNS);
    case (state_q)
      S_CLEAR: we = 1'b1;
      S_BLANK: we = 1'b1;
      S_SCR_WR: begin
        we    = 1'b1;
        wdata = rdata_q;
      end
      S_READ: raddr = addr_of(c_q.rd_row, c_q.rd_col);
      S_IDLE: begin
        raddr = addr_of(cmd_i.rd_row, cmd_i.rd_col);
        waddr = addr_of(row_q, col_q);
        if (cmd_valid_i && !out_v_q && cmd_i.op == OP_BYTE) begin
          if (cmd_i.ch == CH_BS || cmd_i.ch == CH_DEL) begin
            we    = col_q != '0;
            waddr = addr_of(row_q, col_q - 7'd1);
          end else if (!(cmd_i.ch == CH_LF || cmd_i.ch == CH_CR || cmd_i.ch == CH_TAB)) begin
            we    = 1'b1;
            wdata = {attr_q, cmd_i.ch};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      ptr_q    <= '0;
      end_q    <= '0;
      row_q    <= '0;
      col_q    <= '0;
      attr_q   <= ATTR_RESET;
      sidx_q   <= '0;
      isread_q <= 1'b0;
      out_v_q  <= 1'b0;
      cmd_pop_o <= 1'b0;
      c_q      <= '0;
      out_q    <= '0;
    end else begin
      cmd_pop_o <= 1'b0;
      if (out_v_q && !out_stall_i) out_v_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          if (ptr_q == ADDR_W'(CELLS - 1)) begin
            state_q <= S_IDLE;
          end
          ptr_q <= ptr_q + 1'b1;
        end
        S_IDLE: begin
          if (cmd_valid_i && !out_v_q && !cmd_pop_o) begin
            c_q      <= cmd_i;
            cmd_pop_o <= 1'b1;
            isread_q <= 1'b0;
            state_q  <= S_OUT;
            case (cmd_i.op)
              OP_READ: begin
                isread_q <= 1'b1;
                state_q  <= S_READ;
              end
              OP_BYTE: begin
                if (cmd_i.ch == CH_LF) begin
                  col_q <= '0;
                  if (row_q == 5'(ROWS - 1)) begin
                    ptr_q    <= '0;
                    state_q  <= S_SCR_RD;
                  end else row_q <= row_q + 1'b1;
                end else if (cmd_i.ch == CH_CR) begin
                  col_q <= '0;
                end else if (cmd_i.ch == CH_BS || cmd_i.ch == CH_DEL) begin
                  if (col_q != '0) col_q <= col_q - 1'b1;
                end else if (cmd_i.ch == CH_TAB) begin
                  col_q <= ((col_q & 7'h78) + 7'd8 > 7'(COLUMNS - 1)) ? 7'(COLUMNS - 1)
                           : (col_q & 7'h78) + 7'd8;
                end else begin
                  if (col_q == 7'(COLUMNS - 1)) begin
                    col_q <= '0;
                    if (row_q == 5'(ROWS - 1)) begin
                      ptr_q    <= '0;
                      state_q  <= S_SCR_RD;
                    end else row_q <= row_q + 1'b1;
                  end else col_q <= col_q + 1'b1;
                end
              end
              OP_NONE: ;
              default: state_q <= S_SGR;
            endcase
          end
        end
        S_READ: state_q <= S_OUT;
        S_SCR_RD: state_q <= S_SCR_WR;
        S_SCR_WR: begin
          ptr_q <= ptr_q + 1'b1;
          if (ptr_q == ADDR_W'(CELLS - COLUMNS - 1)) begin
            end_q   <= ADDR_W'(CELLS - 1);
            state_q <= S_BLANK;
          end else state_q <= S_SCR_RD;
        end
        S_BLANK: begin
          ptr_q <= ptr_q + 1'b1;
          if (ptr_q == end_q) state_q <= S_OUT;
        end
        S_SGR: begin
          // First cycle dispatches the CSI final byte; 'm' iterates params.
          state_q <= S_OUT;
          if (c_q.ch == 8'h6D) begin
            if (sidx_q < c_q.pcount) begin
              if (sp == 14'd0) attr_q <= def_attr_i;
              else if (sp == 14'd1) attr_q <= attr_q | 8'h08;
              else if (sp >= 14'd30 && sp <= 14'd37)
                attr_q <= {attr_q[7:3], color_map(sp[2:0] - 3'd6)};
              else if (sp >= 14'd40 && sp <= 14'd47)
                attr_q <= {1'b0, color_map(sp[2:0]), attr_q[3:0]};
              else if (sp == 14'd7) attr_q <= {attr_q[3:0], attr_q[7:4]};
              sidx_q  <= sidx_q + 1'b1;
              state_q <= S_SGR;
            end else begin
              if (c_q.pcount == '0) attr_q <= def_attr_i;
              sidx_q <= '0;
            end
          end else begin
            case (c_q.ch)
              8'h41: row_q <= (14'(row_q) >= nmv) ? row_q - nmv[4:0] : '0;
              8'h42: row_q <= (14'(row_q) + nmv >= 14'(ROWS)) ? 5'(ROWS - 1)
                              : row_q + nmv[4:0];
              8'h43: col_q <= (14'(col_q) + nmv >= 14'(COLUMNS)) ? 7'(COLUMNS - 1)
                              : col_q + nmv[6:0];
              8'h44: col_q <= (14'(col_q) >= nmv) ? col_q - nmv[6:0] : '0;
              8'h48, 8'h66: begin
                row_q <= ((p0 == 14'd0 ? 14'd0 : p0 - 14'd1) >= 14'(ROWS)) ? 5'(ROWS - 1)
                         : 5'(p0 == 14'd0 ? 14'd0 : p0 - 14'd1);
                col_q <= ((p1 == 14'd0 ? 14'd0 : p1 - 14'd1) >= 14'(COLUMNS))
                         ? 7'(COLUMNS - 1)
                         : 7'(p1 == 14'd0 ? 14'd0 : p1 - 14'd1);
              end
              8'h4A: begin
                if (n0 == 14'd2) begin
                  ptr_q <= '0;
                  end_q <= ADDR_W'(CELLS - 1);
                  row_q <= '0;
                  col_q <= '0;
                  state_q <= S_BLANK;
                end else if (n0 == 14'd0) begin
                  ptr_q <= addr_of(row_q, col_q);
                  end_q <= ADDR_W'(CELLS - 1);
                  state_q <= S_BLANK;
                end
              end
              8'h4B: begin
                if (n0 == 14'd0) begin
                  ptr_q <= addr_of(row_q, col_q);
                  end_q <= addr_of(row_q, 7'(COLUMNS - 1));
                  state_q <= S_BLANK;
                end else if (n0 == 14'd2) begin
                  ptr_q <= addr_of(row_q, '0);
                  end_q <= addr_of(row_q, 7'(COLUMNS - 1));
                  state_q <= S_BLANK;
                end
              end
              default: ;
            endcase
          end
        end
        default: begin
          out_v_q <= 1'b1;
          out_q.cursor_row    <= row_q;
          out_q.cursor_col    <= col_q;
          out_q.attribute_now <= attr_q;
          out_q.parser_mode   <= c_q.mode;
          out_q.cell_data     <= (isread_q && c_q.rd_row < 5'(ROWS) && c_q.rd_col < 7'(COLUMNS))
                                 ? rdata_q : 16'h0000;
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/ansi_text_terminal_engine.sv
// ANSI text terminal engine, top level: parser front, command queue, back end.
// Scroll and erase are sequenced cell by cell; SGR takes one parameter per cycle.
// One item in the back end at a time: it takes no new item until the last one's result is taken.
// Reset: asynchronous, active low; a clearing pass fills all 2000 cells of the screen memory
// with spaces before the first item is carried out; up to two items wait in the queue.
module ansi_text_terminal_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  atte_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output atte_pkg::out_item_t out_data_o
);
  import atte_pkg::*;

  logic [7:0] def_attr_q;
  logic       f_valid, q_full, q_valid, q_pop;
  cmd_t       f_cmd, q_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) def_attr_q <= ATTR_RESET;
    else if (cfg_we_i) def_attr_q <= cfg_wdata_i;
  end

  atte_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .cmd_valid_o(f_valid), .cmd_full_i(q_full), .cmd_o(f_cmd)
  );

  atte_queue u_queue (
    .clk_i, .rst_ni, .push_i(f_valid), .data_i(f_cmd), .full_o(q_full),
    .valid_o(q_valid), .pop_i(q_pop), .data_o(q_cmd)
  );

  atte_back u_back (
    .clk_i, .rst_ni, .def_attr_i(def_attr_q), .cmd_valid_i(q_valid), .cmd_i(q_cmd),
    .cmd_pop_o(q_pop), .out_valid_o, .out_stall_i, .out_data_o
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> in_stall_o) else $error("queue pushed while full");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("queue popped while empty");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

endmodule

>>> verif/tb_ansi_text_terminal_engine.sv
// Testbench for ansi_text_terminal_engine: drives byte and cell-read items,
// predicts cursor, attribute, parser mode and cell contents, checks every result.
// Depends on atte_pkg and the engine RTL only.
`timescale 1ns / 1ps

module tb_ansi_text_terminal_engine;
  import atte_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 60000;
  localparam int unsigned DRAIN_WAIT     = 4500;

  // Tracks the screen as the engine should hold it and keeps results not yet seen.
  class screen_scoreboard;
    logic [15:0]  cells [CELLS];
    int unsigned  row, col, pcount, acc;
    int unsigned  pvals [MAX_PARAMS];
    bit           digit;
    logic [7:0]   attr, dflt;
    logic [1:0]   mode;
    out_item_t    awaited [$];
    int unsigned  mismatches, checked;
    logic [2:0]   hue [8] = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};

    function new();
      dflt = ATTR_RESET;
      attr = ATTR_RESET;
      for (int i = 0; i < CELLS; i++) cells[i] = {ATTR_RESET, SPACE_GLYPH};
      row = 0; col = 0; mode = MODE_NORMAL; pcount = 0; acc = 0; digit = 0;
    endfunction

    function void blank_from(int unsigned r, int unsigned c0);
      for (int unsigned c = c0; c < COLUMNS; c++) cells[r*COLUMNS + c] = {attr, SPACE_GLYPH};
    endfunction

    function void roll_screen_up();
      if (row < ROWS) return;
      for (int i = 0; i + COLUMNS < CELLS; i++) cells[i] = cells[i + COLUMNS];
      row = ROWS - 1;
      blank_from(row, 0);
    endfunction

    function void close_param();
      if (pcount < MAX_PARAMS) begin
        pvals[pcount] = acc;
        pcount++;
      end
      acc = 0;
      digit = 0;
    endfunction

    function int unsigned param_or(int unsigned idx, int unsigned fb);
      return (idx < pcount) ? pvals[idx] : fb;
    endfunction

    function void set_colours();
      for (int unsigned i = 0; i < pcount; i++) begin
        int unsigned p;
        p = pvals[i];
        if (p == 0) attr = dflt;
        else if (p == 1) attr = attr | 8'h08;
        else if (p >= 30 && p <= 37) attr = {attr[7:3], hue[p-30]};
        else if (p >= 40 && p <= 47) attr = {1'b0, hue[p-40], attr[3:0]};
        else if (p == 7) attr = {attr[3:0], attr[7:4]};
      end
      if (pcount == 0) attr = dflt;
    endfunction

    function void run_final(logic [7:0] fin);
      int unsigned n, r, c, m;
      if (digit || pcount == 0) close_param();
      n = param_or(0, 1);
      if (n == 0) n = 1;
      case (fin)
        "A": row = (row >= n) ? row - n : 0;
        "B": row = (row + n < ROWS) ? row + n : ROWS - 1;
        "C": col = (col + n < COLUMNS) ? col + n : COLUMNS - 1;
        "D": col = (col >= n) ? col - n : 0;
        "H", "f": begin
          r = param_or(0, 1);
          c = param_or(1, 1);
          if (r > 0) r--;
          if (c > 0) c--;
          row = (r < ROWS) ? r : ROWS - 1;
          col = (c < COLUMNS) ? c : COLUMNS - 1;
        end
        "J": begin
          m = param_or(0, 0);
          if (m == 2) begin
            for (int unsigned k = 0; k < ROWS; k++) blank_from(k, 0);
            row = 0; col = 0;
          end else if (m == 0) begin
            blank_from(row, col);
            for (int unsigned k = row + 1; k < ROWS; k++) blank_from(k, 0);
          end
        end
        "K": begin
          m = param_or(0, 0);
          if (m == 0) blank_from(row, col);
          else if (m == 2) blank_from(row, 0);
        end
        "m": set_colours();
        default: ;
      endcase
    endfunction

    function void take_char(logic [7:0] ch);
      if (mode == MODE_NORMAL) begin
        if (ch == CH_ESC) mode = MODE_ESC;
        else if (ch == CH_LF) begin
          col = 0; row++; roll_screen_up();
        end else if (ch == CH_CR) col = 0;
        else if (ch == CH_BS || ch == CH_DEL) begin
          if (col > 0) begin
            col--;
            cells[row*COLUMNS + col] = {attr, SPACE_GLYPH};
          end
        end else if (ch == CH_TAB) begin
          col = (col + 8) & ~32'd7;
          if (col >= COLUMNS) col = COLUMNS - 1;
        end else begin
          cells[row*COLUMNS + col] = {attr, ch};
          col++;
          if (col >= COLUMNS) begin
            col = 0; row++;
          end
          roll_screen_up();
        end
      end else if (mode == MODE_ESC) begin
        if (ch == CH_LBR) begin
          mode = MODE_CSI; pcount = 0; acc = 0; digit = 0;
        end else mode = MODE_NORMAL;
      end else begin
        if (ch >= "0" && ch <= "9") begin
          acc = acc * 10 + (ch - "0");
          if (acc > PARAM_LIMIT) acc = PARAM_LIMIT;
          digit = 1;
        end else if (ch == CH_SEMI) close_param();
        else if (ch >= 8'h40 && ch <= 8'h7E) begin
          run_final(ch);
          mode = MODE_NORMAL;
        end else mode = MODE_NORMAL;
      end
    endfunction

    function void note_input(in_item_t it);
      out_item_t o;
      o.cell_data = '0;
      if (!it.kind) take_char(it.char_code);
      else if (it.read_row < ROWS && it.read_col < COLUMNS)
        o.cell_data = cells[it.read_row*COLUMNS + it.read_col];
      o.cursor_row    = row[4:0];
      o.cursor_col    = col[6:0];
      o.attribute_now = attr;
      o.parser_mode   = mode;
      awaited.push_back(o);
    endfunction

    task report(string what, int got, int want);
      $display("mismatch on %s: got 0x%0h, wanted 0x%0h (result %0d)", what, got, want, checked);
      mismatches++;
    endtask

    task check_result(out_item_t got);
      out_item_t w;
      if (awaited.size() == 0) begin
        report("result with nothing outstanding, cell_data", int'(got.cell_data), 0);
        return;
      end
      w = awaited.pop_front();
      if (got.cursor_row !== w.cursor_row) report("cursor_row", got.cursor_row, w.cursor_row);
      if (got.cursor_col !== w.cursor_col) report("cursor_col", got.cursor_col, w.cursor_col);
      if (got.attribute_now !== w.attribute_now)
        report("attribute_now", got.attribute_now, w.attribute_now);
      if (got.cell_data !== w.cell_data) report("cell_data", got.cell_data, w.cell_data);
      if (got.parser_mode !== w.parser_mode) report("parser_mode", got.parser_mode, w.parser_mode);
      checked++;
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;

  screen_scoreboard screen_sb = new();
  bit          calm = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned bytes_sent = 0, reads_sent = 0, sequences_sent = 0;

  always #5 clk_i = ~clk_i;

  ansi_text_terminal_engine DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always @(posedge clk_i) begin
    if (in_valid && !in_stall) screen_sb.note_input(in_data);
    if (out_valid && !out_stall) screen_sb.check_result(out_data);
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_ni) idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL ansi_text_terminal_engine");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  always @(negedge clk_i) out_stall <= !calm && ($urandom_range(99) < 23);

  task send_item(in_item_t it);
    @(negedge clk_i);
    if (!calm && $urandom_range(99) < 23) begin
      in_valid = 1'b0;
      repeat ($urandom_range(4)) @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk_i); while (in_stall);
    if (it.kind) reads_sent++;
    else bytes_sent++;
  endtask

  task send_char(logic [7:0] ch);
    in_item_t it;
    it.kind      = 1'b0;
    it.char_code = ch;
    it.read_row  = 5'($urandom_range(31));
    it.read_col  = 7'($urandom_range(127));
    send_item(it);
  endtask

  task send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task read_cell(int unsigned r, int unsigned c);
    in_item_t it;
    it.kind      = 1'b1;
    it.char_code = 8'($urandom_range(255));
    it.read_row  = 5'(r);
    it.read_col  = 7'(c);
    send_item(it);
  endtask

  task wait_drained();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (screen_sb.awaited.size() != 0) @(negedge clk_i);
  endtask

  task write_default(logic [7:0] v);
    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk_i);
    cfg_we = 1'b0;
    screen_sb.dflt = v;
  endtask

  // One well-formed escape sequence with random parameters; erase-screen kept rare.
  task send_sequence();
    string       finals;
    int unsigned np;
    finals = "ABCDHfKm";
    send_char(CH_ESC);
    send_char(CH_LBR);
    np = $urandom_range(3);
    if ($urandom_range(9) == 0) np = $urandom_range(10, 4);
    for (int unsigned i = 0; i < np; i++) begin
      int unsigned v;
      case ($urandom_range(3))
        0: v = $urandom_range(9);
        1: v = $urandom_range(30, 47);
        2: v = $urandom_range(99);
        default: v = $urandom_range(99999);
      endcase
      if (!($urandom_range(7) == 0 && i == 0)) send_text($sformatf("%0d", v));
      if (i + 1 < np) send_char(CH_SEMI);
    end
    if ($urandom_range(24) == 0) send_char("J");
    else if ($urandom_range(19) == 0) send_char(8'($urandom_range(8'h40, 8'h7E)));
    else send_char(finals[$urandom_range(7)]);
    sequences_sent++;
  endtask

  task random_phase(int unsigned n);
    int unsigned start;
    start = bytes_sent + reads_sent;
    while (bytes_sent + reads_sent - start < n) begin
      calm = ((bytes_sent + reads_sent - start) % 200) < 40;
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5: send_char(8'($urandom_range(8'h20, 8'h7E)));
        6, 7, 8, 9:       send_sequence();
        10, 11, 12:       read_cell($urandom_range(24), $urandom_range(79));
        13:               read_cell($urandom_range(31), $urandom_range(127));
        14: begin
          // newline only now and then, scrolling is slow
          if ($urandom_range(3) == 0) send_char(CH_LF);
          else send_char(CH_CR);
        end
        15: send_char($urandom_range(1) ? CH_BS : CH_DEL);
        16: send_char(CH_TAB);
        17: begin
          send_char(CH_ESC);
          send_char(8'($urandom_range(255)));
        end
        18: begin
          send_char(CH_ESC);
          send_char(CH_LBR);
          send_char(8'($urandom_range(8'h30, 8'h39)));
          send_char($urandom_range(1) ? 8'(8'h80 | $urandom_range(127))
                                      : 8'($urandom_range(8'h1F)));
        end
        default: send_char(8'($urandom_range(255)));
      endcase
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: glyph extremes, controls, dropped escape, saturation, overflowing
    // parameter list, moves past the edges, erases and reads in and off screen.
    send_text("A");
    send_char(8'hFF);
    send_char(8'h01);
    send_char(CH_TAB);
    send_char(CH_BS);
    send_char(CH_DEL);
    send_char(CH_CR);
    send_char(CH_LF);
    send_text("\033X\033[123456A\033[0C\033[99;200H");
    send_text("\033[1;7;31;44;0;32;42;7;1m\033[2K\033[0J\033[3K");
    read_cell(0, 0);
    read_cell(24, 79);
    read_cell(31, 127);
    read_cell(25, 0);
    wait_drained();

    write_default(8'h00);
    send_text("\033[m\033[2J");
    random_phase(180);
    write_default(8'hFF);
    send_text("\033[0m");
    random_phase(180);
    // Hold the sender until the engine has answered everything.
    wait_drained();
    write_default(8'($urandom_range(255)));
    random_phase(110);
    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk_i);

    $display("covered %0d character bytes, %0d cell reads, %0d escape sequences",
             bytes_sent, reads_sent, sequences_sent);
    $display("%0d results compared, %0d mismatches", screen_sb.checked, screen_sb.mismatches);
    if (screen_sb.mismatches == 0 && screen_sb.awaited.size() == 0)
      $display("PASS ansi_text_terminal_engine");
    else
      $display("FAIL ansi_text_terminal_engine");
    $finish;
  end

endmodule

>>> files.f
hdl/atte_pkg.sv
hdl/atte_front.sv
hdl/atte_queue.sv
hdl/atte_back.sv
hdl/ansi_text_terminal_engine.sv
verif/tb_ansi_text_terminal_engine.sv
